/* sv/cpl3d_pkg.sv */
package cpl3d_pkg;

  // Field and internal widths. Every intermediate is held exactly.
  localparam int CoordW = 32;            // input and output coordinates
  localparam int DiffW  = 33;            // p0 - p1 and p0 + p1
  localparam int DotSqW = 65;            // a, b, e
  localparam int DotRW  = 66;            // c, f
  localparam int DetW   = 130;           // a*e - b*b
  localparam int SolW   = 132;           // numerators of s and t
  localparam int NumW   = 166;           // midpoint numerator and divisor
  localparam int QuoW   = 32;            // quotient bits before saturation

  // Latency of one pipelined wide multiplier.
  localparam int MulLat = 3;

  // Saturation limits.
  localparam logic [QuoW-1:0] SatMax = {1'b0, {(QuoW-1){1'b1}}};
  localparam logic [QuoW-1:0] SatMin = {1'b1, {(QuoW-1){1'b0}}};

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NumW-1:0]   num_t;

endpackage

/* sv/closest_point_between_lines_3d_core.sv */
// Channel | Ports                                        | Direction
// input   | in_valid, in_stall, in_p0_*, in_d0_*, ...    | one line pair per transaction
// result  | out_valid, out_stall, out_mid_*, out_lines_* | one midpoint per transaction
//
// One transaction is taken every cycle while in_stall is low. A result passes
// through three chained three-stage wide multipliers and the 32-stage quotient
// pipeline with its offset stage.
// Reset (rst_n, synchronous, active low) clears the valid bits only.
// While a result waits under out_stall the whole pipeline holds, and
// in_stall is raised; nothing is dropped or repeated.
module closest_point_between_lines_3d_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cpl3d_pkg::coord_t in_p0_x,
  input  cpl3d_pkg::coord_t in_p0_y,
  input  cpl3d_pkg::coord_t in_p0_z,
  input  cpl3d_pkg::coord_t in_d0_x,
  input  cpl3d_pkg::coord_t in_d0_y,
  input  cpl3d_pkg::coord_t in_d0_z,
  input  cpl3d_pkg::coord_t in_p1_x,
  input  cpl3d_pkg::coord_t in_p1_y,
  input  cpl3d_pkg::coord_t in_p1_z,
  input  cpl3d_pkg::coord_t in_d1_x,
  input  cpl3d_pkg::coord_t in_d1_y,
  input  cpl3d_pkg::coord_t in_d1_z,
  output logic              out_valid,
  input  logic              out_stall,
  output cpl3d_pkg::coord_t out_mid_x,
  output cpl3d_pkg::coord_t out_mid_y,
  output cpl3d_pkg::coord_t out_mid_z,
  output logic              out_lines_parallel
);
  import cpl3d_pkg::*;

  localparam int DivLat  = QuoW + 1;
  localparam int VldLen  = 3 * MulLat + 3 + DivLat;
  localparam int InDly   = 2 * MulLat + 2;
  localparam int BusW    = 3 * DiffW + 6 * CoordW;
  localparam int SqW     = 2 * CoordW;
  localparam int PrW     = CoordW + DiffW;

  logic en;

  coord_t p0 [3];
  coord_t d0 [3];
  coord_t p1 [3];
  coord_t d1 [3];
  logic signed [DiffW-1:0] rdf  [3];
  logic signed [DiffW-1:0] psum [3];

  logic signed [SqW-1:0] pa [3];
  logic signed [SqW-1:0] pb [3];
  logic signed [SqW-1:0] pe [3];
  logic signed [PrW-1:0] pc [3];
  logic signed [PrW-1:0] pf [3];

  logic signed [DotSqW-1:0] a_r, b_r, e_r;
  logic signed [DotRW-1:0]  c_r, f_r;

  logic signed [2*DotSqW-1:0]     ae, bb;
  logic signed [DotSqW+DotRW-1:0] bf, ce, af, cb;

  logic signed [DetW-1:0] det_r;
  logic signed [SolW-1:0] sn_r, tn_r;

  logic                   par8;
  logic signed [DetW-1:0] den8;
  logic signed [SolW-1:0] sn8, tn8;

  logic [BusW-1:0]         bus_in, bus_out;
  logic signed [DiffW-1:0] psum8 [3];
  coord_t                  d0_8 [3];
  coord_t                  d1_8 [3];

  logic [DetW:0]          pd_in, pd_out;
  logic                   par11;
  logic signed [DetW-1:0] den11;

  logic signed [DetW+DiffW-1:0] mden [3];
  logic signed [CoordW+SolW-1:0] ms [3];
  logic signed [CoordW+SolW-1:0] mt [3];

  num_t nr_nxt [3];
  num_t nr_r   [3];
  num_t dd_r;
  logic par12_r;
  logic par45;

  logic [QuoW-1:0] quo [3];
  coord_t          mid_r [3];
  logic            par_out_r;

  logic [VldLen-1:0] vld_r;
  logic              out_valid_r;

  // The pipeline advances unless a finished result is held back.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign p0 = '{in_p0_x, in_p0_y, in_p0_z};
  assign d0 = '{in_d0_x, in_d0_y, in_d0_z};
  assign p1 = '{in_p1_x, in_p1_y, in_p1_z};
  assign d1 = '{in_d1_x, in_d1_y, in_d1_z};

  // First products: the terms of the five dot products.
  for (genvar k = 0; k < 3; k++) begin : g_dot
    assign rdf[k]  = DiffW'(p0[k]) - DiffW'(p1[k]);
    assign psum[k] = DiffW'(p0[k]) + DiffW'(p1[k]);

    cpl3d_mul #(.WA(CoordW), .WB(CoordW)) u_mul_a (
      .clk(clk), .en(en), .a(d0[k]), .b(d0[k]), .p(pa[k]));
    cpl3d_mul #(.WA(CoordW), .WB(CoordW)) u_mul_b (
      .clk(clk), .en(en), .a(d0[k]), .b(d1[k]), .p(pb[k]));
    cpl3d_mul #(.WA(CoordW), .WB(CoordW)) u_mul_e (
      .clk(clk), .en(en), .a(d1[k]), .b(d1[k]), .p(pe[k]));
    cpl3d_mul #(.WA(CoordW), .WB(DiffW)) u_mul_c (
      .clk(clk), .en(en), .a(d0[k]), .b(rdf[k]), .p(pc[k]));
    cpl3d_mul #(.WA(CoordW), .WB(DiffW)) u_mul_f (
      .clk(clk), .en(en), .a(d1[k]), .b(rdf[k]), .p(pf[k]));
  end

  // Dot product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= DotSqW'(pa[0]) + DotSqW'(pa[1]) + DotSqW'(pa[2]);
      b_r <= DotSqW'(pb[0]) + DotSqW'(pb[1]) + DotSqW'(pb[2]);
      e_r <= DotSqW'(pe[0]) + DotSqW'(pe[1]) + DotSqW'(pe[2]);
      c_r <= DotRW'(pc[0]) + DotRW'(pc[1]) + DotRW'(pc[2]);
      f_r <= DotRW'(pf[0]) + DotRW'(pf[1]) + DotRW'(pf[2]);
    end
  end

  // Second products: determinant and the numerators of s and t.
  cpl3d_mul #(.WA(DotSqW), .WB(DotSqW)) u_mul_ae (
    .clk(clk), .en(en), .a(a_r), .b(e_r), .p(ae));
  cpl3d_mul #(.WA(DotSqW), .WB(DotSqW)) u_mul_bb (
    .clk(clk), .en(en), .a(b_r), .b(b_r), .p(bb));
  cpl3d_mul #(.WA(DotSqW), .WB(DotRW)) u_mul_bf (
    .clk(clk), .en(en), .a(b_r), .b(f_r), .p(bf));
  cpl3d_mul #(.WA(DotSqW), .WB(DotRW)) u_mul_ce (
    .clk(clk), .en(en), .a(e_r), .b(c_r), .p(ce));
  cpl3d_mul #(.WA(DotSqW), .WB(DotRW)) u_mul_af (
    .clk(clk), .en(en), .a(a_r), .b(f_r), .p(af));
  cpl3d_mul #(.WA(DotSqW), .WB(DotRW)) u_mul_cb (
    .clk(clk), .en(en), .a(b_r), .b(c_r), .p(cb));

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= DetW'(ae) - DetW'(bb);
      sn_r  <= SolW'(bf) - SolW'(ce);
      tn_r  <= SolW'(af) - SolW'(cb);
    end
  end

  // A determinant that is not positive means parallel lines: the midpoint of
  // the two points is returned through the same datapath.
  assign par8 = det_r[DetW-1] || (det_r == '0);
  assign den8 = par8 ? DetW'(1) : det_r;
  assign sn8  = par8 ? '0 : sn_r;
  assign tn8  = par8 ? '0 : tn_r;

  // Point sums and directions wait for the determinant.
  assign bus_in = {psum[0], psum[1], psum[2], d0[0], d0[1], d0[2], d1[0], d1[1], d1[2]};

  cpl3d_dly #(.W(BusW), .N(InDly)) u_dly_in (
    .clk(clk), .en(en), .din(bus_in), .dout(bus_out));

  assign {psum8[0], psum8[1], psum8[2], d0_8[0], d0_8[1], d0_8[2],
          d1_8[0], d1_8[1], d1_8[2]} = bus_out;

  assign pd_in = {par8, den8};

  cpl3d_dly #(.W(DetW + 1), .N(MulLat)) u_dly_den (
    .clk(clk), .en(en), .din(pd_in), .dout(pd_out));

  assign {par11, den11} = pd_out;

  // Third products and the rounded midpoint numerator for each axis.
  for (genvar k = 0; k < 3; k++) begin : g_mid
    cpl3d_mul #(.WA(DetW), .WB(DiffW)) u_mul_den (
      .clk(clk), .en(en), .a(den8), .b(psum8[k]), .p(mden[k]));
    cpl3d_mul #(.WA(CoordW), .WB(SolW)) u_mul_s (
      .clk(clk), .en(en), .a(d0_8[k]), .b(sn8), .p(ms[k]));
    cpl3d_mul #(.WA(CoordW), .WB(SolW)) u_mul_t (
      .clk(clk), .en(en), .a(d1_8[k]), .b(tn8), .p(mt[k]));

    assign nr_nxt[k] = NumW'(mden[k]) + NumW'(ms[k]) + NumW'(mt[k]) + NumW'(den11);

    cpl3d_div u_div (
      .clk(clk), .en(en), .nr(nr_r[k]), .dd(dd_r), .q(quo[k]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr_r    <= nr_nxt;
      dd_r    <= NumW'(den11) <<< 1;
      par12_r <= par11;
    end
  end

  cpl3d_dly #(.W(1), .N(DivLat)) u_dly_par (
    .clk(clk), .en(en), .din(par12_r), .dout(par45));

  // Result register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mid_r[k] <= quo[k];
      end
      par_out_r <= par45;
    end
  end

  // Valid bits travel beside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VldLen-2:0], in_valid};
      out_valid_r <= vld_r[VldLen-1];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mid_x          = mid_r[0];
  assign out_mid_y          = mid_r[1];
  assign out_mid_z          = mid_r[2];
  assign out_lines_parallel = par_out_r;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("Accepted transaction did not enter the pipeline.");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("Pipeline valid bits moved during a stall.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");
`endif

endmodule

/* sv/cpl3d_dly.sv */
module cpl3d_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [N];

  // Shift line that advances with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[N-1];

endmodule

/* sv/cpl3d_mul.sv */
module cpl3d_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  // Operands are cut into 32-bit unsigned chunks with a signed top chunk
  // of up to 33 bits, so every partial product is a 33 x 33 signed multiply.
  localparam int NA    = (WA + 30) / 32;
  localparam int NB    = (WB + 30) / 32;
  localparam int AExtW = 32 * NA + 1;
  localparam int BExtW = 32 * NB + 1;
  localparam int WP    = WA + WB;

  logic signed [AExtW-1:0] a_ext;
  logic signed [BExtW-1:0] b_ext;
  logic signed [32:0]      a_op [NA];
  logic signed [32:0]      b_op [NB];
  logic signed [65:0]      pp_r [NA][NB];
  logic signed [WP-1:0]    row_nxt [NB];
  logic signed [WP-1:0]    row_r [NB];
  logic signed [WP-1:0]    p_nxt;
  logic signed [WP-1:0]    p_r;

  assign a_ext = AExtW'(a);
  assign b_ext = BExtW'(b);

  for (genvar i = 0; i < NA; i++) begin : g_aop
    if (i == NA - 1) begin : g_top
      assign a_op[i] = a_ext[32*i +: 33];
    end else begin : g_low
      assign a_op[i] = {1'b0, a_ext[32*i +: 32]};
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bop
    if (j == NB - 1) begin : g_top
      assign b_op[j] = b_ext[32*j +: 33];
    end else begin : g_low
      assign b_op[j] = {1'b0, b_ext[32*j +: 32]};
    end
  end

  // Second stage: one row sum for each chunk of b.
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_nxt[j] = row_nxt[j] + (WP'(pp_r[i][j]) <<< (32 * (i + j)));
      end
    end
  end

  // Third stage: sum of the rows.
  always_comb begin
    p_nxt = '0;
    for (int j = 0; j < NB; j++) begin
      p_nxt = p_nxt + row_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= a_op[i] * b_op[j];
        end
      end
      row_r <= row_nxt;
      p_r   <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

/* sv/cpl3d_div.sv */
module cpl3d_div (
  input  logic                          clk,
  input  logic                          en,
  input  cpl3d_pkg::num_t               nr,
  input  cpl3d_pkg::num_t               dd,
  output logic [cpl3d_pkg::QuoW-1:0]    q
);
  import cpl3d_pkg::*;

  // floor(nr / dd) for dd > 0, saturated to QuoW bits. The numerator is
  // offset by 2^(QuoW-1) * dd so that an in-range quotient is unsigned and
  // below 2^QuoW; one quotient bit is then resolved in each stage.
  num_t            thr;
  logic            lo_nxt;
  logic            hi_nxt;
  logic [NumW-1:0] np_nxt;

  logic [NumW-1:0] np_r;
  logic [NumW-1:0] dv0_r;
  logic            lo0_r;
  logic            hi0_r;

  logic [NumW-1:0] rem_in [QuoW];
  logic [NumW-1:0] dv_in  [QuoW];
  logic [QuoW-1:0] quo_in [QuoW];
  logic            lo_in  [QuoW];
  logic            hi_in  [QuoW];
  logic [NumW-1:0] dsh    [QuoW];
  logic            ge     [QuoW];

  logic [NumW-1:0] rem_r [QuoW];
  logic [NumW-1:0] dv_r  [QuoW];
  logic [QuoW-1:0] quo_r [QuoW];
  logic            lo_r  [QuoW];
  logic            hi_r  [QuoW];

  // Range check and offset of the numerator.
  assign thr    = dd <<< (QuoW - 1);
  assign lo_nxt = (nr < -thr);
  assign hi_nxt = (nr >= thr);
  assign np_nxt = nr + thr;

  always_ff @(posedge clk) begin
    if (en) begin
      np_r  <= np_nxt;
      dv0_r <= dd;
      lo0_r <= lo_nxt;
      hi0_r <= hi_nxt;
    end
  end

  // Restoring quotient stages, most significant bit first.
  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = np_r;
      assign dv_in[s]  = dv0_r;
      assign quo_in[s] = '0;
      assign lo_in[s]  = lo0_r;
      assign hi_in[s]  = hi0_r;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign dv_in[s]  = dv_r[s-1];
      assign quo_in[s] = quo_r[s-1];
      assign lo_in[s]  = lo_r[s-1];
      assign hi_in[s]  = hi_r[s-1];
    end

    assign dsh[s] = dv_in[s] << (QuoW - 1 - s);
    assign ge[s]  = (rem_in[s] >= dsh[s]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge[s] ? (rem_in[s] - dsh[s]) : rem_in[s];
        quo_r[s] <= {quo_in[s][QuoW-2:0], ge[s]};
        dv_r[s]  <= dv_in[s];
        lo_r[s]  <= lo_in[s];
        hi_r[s]  <= hi_in[s];
      end
    end
  end

  // Remove the offset, or clamp.
  assign q = lo_r[QuoW-1] ? SatMin :
             hi_r[QuoW-1] ? SatMax : (quo_r[QuoW-1] ^ SatMin);

endmodule
